/* rtl/wlpt_pkg.sv */
`default_nettype none

package wlpt_pkg;

  // Width and reset value of the degenerate-norm threshold register.
  localparam int unsigned THRESH_WIDTH = 16;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd2;

  // Control that travels with each word through the front stages.
  typedef struct packed {
    logic valid;
    logic deg;
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/wlpt_front.sv */
`default_nettype none

module wlpt_front
  import wlpt_pkg::*;
#(
  parameter int unsigned PW = 24,
  parameter int unsigned QW = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [2:0][PW-1:0]       pnt,
  input  wire logic [2:0][PW-1:0]       rfp,
  input  wire logic [3:0][QW-1:0]       quat,
  input  wire logic [THRESH_WIDTH-1:0]  thresh,
  output ctl_t                          out_ctl,
  output logic [2:0][PW:0]              diff,
  output logic [8:0][2*QW+1:0]          mat,
  output logic [2*QW:0]                 norm
);

  localparam int unsigned DW = PW + 1;
  localparam int unsigned PQ = 2 * QW;
  localparam int unsigned MW = 2 * QW + 2;
  localparam int unsigned NW = 2 * QW + 1;

  // Stage 1: exact differences and the ten quaternion products.
  // Product order: ww, xx, yy, zz, xy, wz, xz, wy, yz, wx.
  logic                 s1_valid;
  logic signed [DW-1:0] s1_d [3];
  logic signed [PQ-1:0] s1_p [10];
  logic signed [QW-1:0] qv [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qv[k] = $signed(quat[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_d[i] <= DW'($signed(pnt[i])) - DW'($signed(rfp[i]));
    end
    s1_p[0] <= PQ'(qv[0]) * PQ'(qv[0]);
    s1_p[1] <= PQ'(qv[1]) * PQ'(qv[1]);
    s1_p[2] <= PQ'(qv[2]) * PQ'(qv[2]);
    s1_p[3] <= PQ'(qv[3]) * PQ'(qv[3]);
    s1_p[4] <= PQ'(qv[1]) * PQ'(qv[2]);
    s1_p[5] <= PQ'(qv[0]) * PQ'(qv[3]);
    s1_p[6] <= PQ'(qv[1]) * PQ'(qv[3]);
    s1_p[7] <= PQ'(qv[0]) * PQ'(qv[2]);
    s1_p[8] <= PQ'(qv[2]) * PQ'(qv[3]);
    s1_p[9] <= PQ'(qv[0]) * PQ'(qv[1]);
  end

  // Stage 2: transposed rotation matrix, squared norm and degenerate test.
  logic signed [MW-1:0] e [10];
  logic signed [MW-1:0] m_next [9];
  logic [NW-1:0]        n_next;

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      e[k] = MW'(s1_p[k]);
    end
    m_next[0] = e[0] + e[1] - e[2] - e[3];
    m_next[1] = (e[4] + e[5]) <<< 1;
    m_next[2] = (e[6] - e[7]) <<< 1;
    m_next[3] = (e[4] - e[5]) <<< 1;
    m_next[4] = e[0] - e[1] + e[2] - e[3];
    m_next[5] = (e[8] + e[9]) <<< 1;
    m_next[6] = (e[6] + e[7]) <<< 1;
    m_next[7] = (e[8] - e[9]) <<< 1;
    m_next[8] = e[0] - e[1] - e[2] + e[3];
    n_next = NW'($unsigned(s1_p[0])) + NW'($unsigned(s1_p[1]))
           + NW'($unsigned(s1_p[2])) + NW'($unsigned(s1_p[3]));
  end

  always_ff @(posedge clk) begin
    out_ctl.deg <= (n_next <= NW'(thresh));
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    norm <= n_next;
    for (int i = 0; i < 3; i++) begin
      diff[i] <= $unsigned(s1_d[i]);
    end
    for (int k = 0; k < 9; k++) begin
      mat[k] <= $unsigned(m_next[k]);
    end
  end

endmodule

`default_nettype wire

/* rtl/wlpt_rotate.sv */
`default_nettype none

module wlpt_rotate
  import wlpt_pkg::*;
#(
  parameter int unsigned PW = 24,
  parameter int unsigned QW = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_t                in_ctl,
  input  wire logic [2:0][PW:0]    in_diff,
  input  wire logic [8:0][2*QW+1:0] in_mat,
  input  wire logic [2*QW:0]       in_norm,
  output ctl_t                     out_ctl,
  output logic [2:0][PW:0]         out_diff,
  output logic [2*QW:0]            out_norm,
  output logic [2:0]               sign,
  output logic [2:0][2*QW+PW+4:0]  mag
);

  localparam int unsigned DW  = PW + 1;
  localparam int unsigned MW  = 2 * QW + 2;
  localparam int unsigned NW  = 2 * QW + 1;
  localparam int unsigned PRW = MW + DW;
  localparam int unsigned AW  = PRW + 2;

  // Stage 3: the nine matrix by difference products.
  ctl_t                  s3_ctl;
  logic [2:0][DW-1:0]    s3_diff;
  logic [NW-1:0]         s3_norm;
  logic signed [PRW-1:0] s3_p [9];

  always_ff @(posedge clk) begin
    s3_ctl.deg <= in_ctl.deg;
    if (rst) begin
      s3_ctl.valid <= 1'b0;
    end else begin
      s3_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_diff    <= in_diff;
    s3_norm    <= in_norm;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_p[3*i+j] <= PRW'($signed(in_mat[3*i+j])) * PRW'($signed(in_diff[j]));
      end
    end
  end

  // Stage 4: row sums of the rotated numerator.
  ctl_t                 s4_ctl;
  logic [2:0][DW-1:0]   s4_diff;
  logic [NW-1:0]        s4_norm;
  logic signed [AW-1:0] s4_acc [3];

  always_ff @(posedge clk) begin
    s4_ctl.deg <= s3_ctl.deg;
    if (rst) begin
      s4_ctl.valid <= 1'b0;
    end else begin
      s4_ctl.valid <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_diff    <= s3_diff;
    s4_norm    <= s3_norm;
    for (int i = 0; i < 3; i++) begin
      s4_acc[i] <= AW'(s3_p[3*i]) + AW'(s3_p[3*i+1]) + AW'(s3_p[3*i+2]);
    end
  end

  // Stage 5: magnitude plus half the norm, so the divider rounds to nearest.
  always_ff @(posedge clk) begin
    out_ctl.deg <= s4_ctl.deg;
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= s4_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_diff    <= s4_diff;
    out_norm    <= s4_norm;
    for (int i = 0; i < 3; i++) begin
      sign[i] <= s4_acc[i][AW-1];
      mag[i]  <= (s4_acc[i][AW-1] ? ~$unsigned(s4_acc[i]) : $unsigned(s4_acc[i]))
               + AW'(s4_norm >> 1) + AW'(s4_acc[i][AW-1]);
    end
  end

endmodule

`default_nettype wire

/* rtl/wlpt_div.sv */
`default_nettype none

module wlpt_div #(
  parameter int unsigned PW = 24,
  parameter int unsigned QW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [2*QW+PW+4:0] in_mag,
  input  wire logic [2*QW:0]      in_norm,
  output logic                    out_valid,
  output logic [PW-1:0]           quo,
  output logic                    ovf
);

  localparam int unsigned NW = 2 * QW + 1;
  localparam int unsigned AW = 2 * QW + PW + 5;
  localparam int unsigned HW = AW - PW;

  // One restoring step per stage; stage zero checks for a quotient that
  // cannot fit in PW bits and seeds the remainder with the upper bits.
  logic          v   [PW+1];
  logic [NW-1:0] rem [PW+1];
  logic [PW-1:0] lo  [PW+1];
  logic [PW-1:0] q   [PW+1];
  logic [NW-1:0] n   [PW+1];
  logic          ov  [PW+1];

  logic [HW-1:0] hi;
  logic          hi_ge;

  assign hi    = in_mag[AW-1:PW];
  assign hi_ge = (hi >= HW'(in_norm));

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ov[0]  <= hi_ge;
    rem[0] <= hi_ge ? '0 : hi[NW-1:0];
    lo[0]  <= in_mag[PW-1:0];
    q[0]   <= '0;
    n[0]   <= in_norm;
  end

  for (genvar k = 1; k <= PW; k++) begin : g_step
    logic [NW:0] t;
    logic        ge;
    logic [NW:0] diff;

    assign t    = {rem[k-1], lo[k-1][PW-k]};
    assign ge   = (t >= {1'b0, n[k-1]});
    assign diff = t - {1'b0, n[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[NW-1:0] : t[NW-1:0];
      q[k]   <= {q[k-1][PW-2:0], ge};
      lo[k]  <= lo[k-1];
      n[k]   <= n[k-1];
      ov[k]  <= ov[k-1];
    end
  end

  assign out_valid = v[PW];
  assign quo       = q[PW];
  assign ovf       = ov[PW];

`ifndef SYNTHESIS
  // The remainder stays below a nonzero divisor at entry to and exit from the pipeline.
  a_rem_first : assert property (@(posedge clk) disable iff (rst)
    (v[0] && !ov[0] && n[0] != '0) |-> (rem[0] < n[0]))
    else $error("divider remainder not below divisor at entry");
  a_rem_last : assert property (@(posedge clk) disable iff (rst)
    (v[PW] && !ov[PW] && n[PW] != '0) |-> (rem[PW] < n[PW]))
    else $error("divider remainder not below divisor at exit");
  a_valid_flow : assert property (@(posedge clk) disable iff (rst)
    v[0] |=> ##(PW-1) v[PW])
    else $error("divider lost a word");
`endif

endmodule

`default_nettype wire

/* rtl/wrist_local_point_transform.sv */
`default_nettype none

// Throughput: one word per cycle; the pipeline has no back pressure and busy
// is high only during reset. The divider spends one stage per quotient bit,
// which sets the depth. Reset is synchronous and active high; it clears the
// valid bits and loads the threshold register with 2. cfg_ready is always high.

module wrist_local_point_transform
  import wlpt_pkg::*;
#(
  parameter int unsigned POS_WIDTH  = 24,
  parameter int unsigned QUAT_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [THRESH_WIDTH-1:0] cfg_data,
  input  wire logic [POS_WIDTH-1:0]    point_x,
  input  wire logic [POS_WIDTH-1:0]    point_y,
  input  wire logic [POS_WIDTH-1:0]    point_z,
  input  wire logic [POS_WIDTH-1:0]    ref_x,
  input  wire logic [POS_WIDTH-1:0]    ref_y,
  input  wire logic [POS_WIDTH-1:0]    ref_z,
  input  wire logic [QUAT_WIDTH-1:0]   quat_w,
  input  wire logic [QUAT_WIDTH-1:0]   quat_x,
  input  wire logic [QUAT_WIDTH-1:0]   quat_y,
  input  wire logic [QUAT_WIDTH-1:0]   quat_z,
  output logic                         done,
  output logic [POS_WIDTH-1:0]         local_x,
  output logic [POS_WIDTH-1:0]         local_y,
  output logic [POS_WIDTH-1:0]         local_z,
  output logic                         degenerate,
  output logic                         saturated
);

  localparam int unsigned PW  = POS_WIDTH;
  localparam int unsigned QW  = QUAT_WIDTH;
  localparam int unsigned DW  = PW + 1;
  localparam int unsigned MW  = 2 * QW + 2;
  localparam int unsigned NW  = 2 * QW + 1;
  localparam int unsigned AW  = 2 * QW + PW + 5;
  localparam int unsigned SBW = 4 + 3 * DW;
  localparam int unsigned DLY = PW + 1;

  localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};

  // Handshake and threshold register.
  logic [THRESH_WIDTH-1:0] thresh;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  // Front end: differences, matrix and norm.
  ctl_t                 f_ctl;
  logic [2:0][DW-1:0]   f_diff;
  logic [8:0][MW-1:0]   f_mat;
  logic [NW-1:0]        f_norm;

  wlpt_front #(.PW(PW), .QW(QW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .pnt      ({point_z, point_y, point_x}),
    .rfp      ({ref_z, ref_y, ref_x}),
    .quat     ({quat_z, quat_y, quat_x, quat_w}),
    .thresh   (thresh),
    .out_ctl  (f_ctl),
    .diff     (f_diff),
    .mat      (f_mat),
    .norm     (f_norm)
  );

  // Rotation products, sums and rounding offset.
  ctl_t               r_ctl;
  logic [2:0][DW-1:0] r_diff;
  logic [NW-1:0]      r_norm;
  logic [2:0]         r_sign;
  logic [2:0][AW-1:0] r_mag;

  wlpt_rotate #(.PW(PW), .QW(QW)) u_rotate (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (f_ctl),
    .in_diff  (f_diff),
    .in_mat   (f_mat),
    .in_norm  (f_norm),
    .out_ctl  (r_ctl),
    .out_diff (r_diff),
    .out_norm (r_norm),
    .sign     (r_sign),
    .mag      (r_mag)
  );

  // One pipelined divider per axis.
  logic [2:0]         d_valid;
  logic [2:0][PW-1:0] d_quo;
  logic [2:0]         d_ovf;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    wlpt_div #(.PW(PW), .QW(QW)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (r_ctl.valid),
      .in_mag    (r_mag[i]),
      .in_norm   (r_norm),
      .out_valid (d_valid[i]),
      .quo       (d_quo[i]),
      .ovf       (d_ovf[i])
    );
  end

  // Side data follows the divider through a delay line of equal depth.
  logic [SBW-1:0] sb [DLY];

  always_ff @(posedge clk) begin
    sb[0] <= {r_ctl.deg, r_sign, r_diff};
    for (int k = 1; k < DLY; k++) begin
      sb[k] <= sb[k-1];
    end
  end

  logic               o_deg;
  logic [2:0]         o_sign;
  logic [2:0][DW-1:0] o_diff;

  assign {o_deg, o_sign, o_diff} = sb[DLY-1];

  // Final clipping to the position range.
  logic [2:0][PW-1:0] val;
  logic [2:0]         clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (o_deg) begin
        clip[i] = o_diff[i][DW-1] ^ o_diff[i][DW-2];
        val[i]  = clip[i] ? (o_diff[i][DW-1] ? POS_MIN : POS_MAX) : o_diff[i][PW-1:0];
      end else if (o_sign[i]) begin
        clip[i] = d_ovf[i] || (d_quo[i] > POS_MIN);
        val[i]  = clip[i] ? POS_MIN : (~d_quo[i] + PW'(1));
      end else begin
        clip[i] = d_ovf[i] || (d_quo[i] > POS_MAX);
        val[i]  = clip[i] ? POS_MAX : d_quo[i];
      end
    end
  end

  // Output register; flags read zero when no word is shown.
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      degenerate <= 1'b0;
      saturated  <= 1'b0;
    end else begin
      done       <= d_valid[0];
      degenerate <= d_valid[0] && o_deg;
      saturated  <= d_valid[0] && (|clip);
    end
  end

  always_ff @(posedge clk) begin
    local_x <= val[0];
    local_y <= val[1];
    local_z <= val[2];
  end

`ifndef SYNTHESIS
  // Flags only accompany a word.
  a_flags_with_done : assert property (@(posedge clk) disable iff (rst)
    (degenerate || saturated) |-> done)
    else $error("flag raised without a result word");
  // A clipped word holds a range limit on some axis.
  a_sat_at_limit : assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (local_x == POS_MIN || local_x == POS_MAX
      || local_y == POS_MIN || local_y == POS_MAX
      || local_z == POS_MIN || local_z == POS_MAX))
    else $error("saturated word holds no range limit");
  // The three axis dividers stay in lockstep.
  a_lanes_aligned : assert property (@(posedge clk) disable iff (rst)
    (d_valid[0] == d_valid[1]) && (d_valid[1] == d_valid[2]))
    else $error("divider lanes out of step");
  // Reset empties the pipeline.
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");
`endif

endmodule

`default_nettype wire
